@@ sv/fsp_pkg.sv @@
// Shared types, constants and helpers for the frame sync and pattern checker.
package fsp_pkg;

	// Default width of the frame byte counter
	localparam int FSP_INDEX_BITS = 24;
	// Depth of the classified-beat queue between front and back
	localparam int FSP_QUEUE_DEPTH = 4;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MARKER_WORD  = 2'd2;
	localparam logic [1:0] REG_SYNC_MARKERS = 2'd3;

	// Reset values of the configuration registers
	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd250;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd200;
	localparam logic [31:0] MARKER_WORD_RST  = 32'hAA55_AA55;
	localparam logic [1:0]  SYNC_MARKERS_RST = 2'd2;

	// Test pattern bytes that are swapped out
	localparam logic [7:0] PAT_AA = 8'hAA;
	localparam logic [7:0] PAT_AB = 8'hAB;
	localparam logic [7:0] PAT_55 = 8'h55;
	localparam logic [7:0] PAT_56 = 8'h56;
	localparam logic [7:0] PAT_FF = 8'hFF;
	localparam logic [7:0] PAT_FE = 8'hFE;

	typedef enum logic [1:0] {
		PH_SYNC  = 2'd0,
		PH_FRAME = 2'd1,
		PH_HUNT  = 2'd2
	} fsp_phase_t;

	// One classified beat, as handed from front to back
	typedef struct packed {
		logic [1:0] phase;
		logic       valid;
		logic [7:0] pix;
		logic       fend;
		logic       fgood;
	} fsp_rec_t;

	// Expected first-row byte for a column (low byte of the column number, with the three pattern bytes swapped)
	function automatic logic [7:0] fsp_expected(input logic [7:0] col);
		logic [7:0] e;
		e = col;
		case (col)
			PAT_AA:  e = PAT_AB;
			PAT_55:  e = PAT_56;
			PAT_FF:  e = PAT_FE;
			default: e = col;
		endcase
		return e;
	endfunction

endpackage

@@ sv/fsp_queue.sv @@
// Short register queue that decouples the front classifier from the back end.
module fsp_queue import fsp_pkg::*; #(
	parameter int DEPTH = FSP_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  fsp_rec_t wdata,
	input  logic     rd,
	output fsp_rec_t rdata,
	output logic     full,
	output logic     empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	fsp_rec_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;
	assign rdata = mem_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/fsp_front.sv @@
// Front end: configuration registers, marker hunt and frame byte classification.
module fsp_front import fsp_pkg::*; #(
	parameter int INDEX_BITS = FSP_INDEX_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        take,
	input  logic [7:0]  rx_byte,
	output fsp_rec_t    rec
);

	// Last byte index of a frame: width*height clamped to the counter range, minus one
	function automatic logic [INDEX_BITS-1:0] last_of(input logic [11:0] w,
		input logic [11:0] h);
		logic [11:0] wn;
		logic [11:0] hn;
		logic [32:0] tot;
		logic [32:0] lim;
		wn  = (w == 12'd0) ? 12'd1 : w;
		hn  = (h == 12'd0) ? 12'd1 : h;
		tot = 33'({12'd0, wn} * {12'd0, hn});
		lim = 33'd1 << INDEX_BITS;
		if (tot > lim) begin
			tot = lim;
		end
		return INDEX_BITS'(tot - 33'd1);
	endfunction

	logic [11:0]           width_q;
	logic [11:0]           height_q;
	logic [31:0]           marker_q;
	logic [1:0]            sync_q;
	logic [INDEX_BITS-1:0] last_q;

	fsp_phase_t            phase_q, phase_n;
	logic [23:0]           win_q, win_n;
	logic [1:0]            fill_q, fill_n;
	logic [1:0]            found_q, found_n;
	logic [INDEX_BITS-1:0] idx_q, idx_n;
	logic                  row_q, row_n;

	logic [31:0] word;
	logic        hit;
	logic [11:0] width_eff;
	logic        first_row;
	logic        mismatch;
	logic        row_ok;
	logic [1:0]  found_inc;

	// Configuration registers; the frame length is recomputed on each size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
			marker_q <= MARKER_WORD_RST;
			sync_q   <= SYNC_MARKERS_RST;
			last_q   <= last_of(FRAME_WIDTH_RST, FRAME_HEIGHT_RST);
		end else if (wr_en) begin
			case (wr_index)
				REG_FRAME_WIDTH: begin
					width_q <= wr_data[11:0];
					last_q  <= last_of(wr_data[11:0], height_q);
				end
				REG_FRAME_HEIGHT: begin
					height_q <= wr_data[11:0];
					last_q   <= last_of(width_q, wr_data[11:0]);
				end
				REG_MARKER_WORD: marker_q <= wr_data;
				REG_SYNC_MARKERS: sync_q <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// Marker window and first-row check terms
	assign word      = {win_q, rx_byte};
	assign hit       = (fill_q == 2'd3) && (word == marker_q);
	assign width_eff = (width_q == 12'd0) ? 12'd1 : width_q;
	assign first_row = 33'(idx_q) < 33'(width_eff);
	assign mismatch  = first_row && (rx_byte != fsp_expected(idx_q[7:0]));
	assign row_ok    = row_q & ~mismatch;
	assign found_inc = (found_q == 2'd3) ? 2'd3 : found_q + 2'd1;

	// Next state and classification of the current beat
	always_comb begin
		phase_n = phase_q;
		win_n   = win_q;
		fill_n  = fill_q;
		found_n = found_q;
		idx_n   = idx_q;
		row_n   = row_q;
		rec       = '0;
		rec.phase = phase_q;
		case (phase_q)
			PH_FRAME: begin
				rec.valid = 1'b1;
				rec.pix   = rx_byte;
				row_n     = row_ok;
				if (idx_q >= last_q) begin
					rec.fend  = 1'b1;
					rec.fgood = row_ok;
					phase_n   = PH_HUNT;
					win_n     = '0;
					fill_n    = '0;
					idx_n     = '0;
					row_n     = 1'b1;
				end else begin
					idx_n = idx_q + 1'b1;
				end
			end
			PH_SYNC: begin
				if (hit) begin
					win_n   = '0;
					fill_n  = '0;
					found_n = found_inc;
					if (found_inc >= sync_q) begin
						phase_n = PH_FRAME;
						idx_n   = '0;
						row_n   = 1'b1;
					end
				end else begin
					win_n  = word[23:0];
					fill_n = (fill_q == 2'd3) ? 2'd3 : fill_q + 2'd1;
				end
			end
			default: begin
				if (hit) begin
					win_n   = '0;
					fill_n  = '0;
					phase_n = PH_FRAME;
					idx_n   = '0;
					row_n   = 1'b1;
				end else begin
					win_n  = word[23:0];
					fill_n = (fill_q == 2'd3) ? 2'd3 : fill_q + 2'd1;
				end
			end
		endcase
	end

	// Commit state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC;
			win_q   <= '0;
			fill_q  <= '0;
			found_q <= '0;
			idx_q   <= '0;
			row_q   <= 1'b1;
		end else if (take) begin
			phase_q <= phase_n;
			win_q   <= win_n;
			fill_q  <= fill_n;
			found_q <= found_n;
			idx_q   <= idx_n;
			row_q   <= row_n;
		end
	end

endmodule

@@ sv/fsp_back.sv @@
// Back end: frame counters and the output register facing the result side.
module fsp_back import fsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  fsp_rec_t    q_rdata,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  phase,
	output logic        pixel_valid,
	output logic [7:0]  pixel_value,
	output logic        frame_end,
	output logic        frame_good,
	output logic [15:0] good_frames,
	output logic [15:0] bad_frames
);

	fsp_rec_t    out_q;
	logic        out_valid_q;
	logic [15:0] good_q;
	logic [15:0] bad_q;
	logic        load;

	// Refill the output register when it is free or being drained
	assign load  = ~q_empty & (~out_valid_q | pop);
	assign q_pop = load;
	assign empty = ~out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			good_q      <= '0;
			bad_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			// Count the frame on its last beat, saturating
			if (load && q_rdata.fend) begin
				if (q_rdata.fgood) begin
					if (good_q != 16'hFFFF) begin
						good_q <= good_q + 16'd1;
					end
				end else if (bad_q != 16'hFFFF) begin
					bad_q <= bad_q + 16'd1;
				end
			end
		end
	end

	// Hold the beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= q_rdata;
		end
	end

	assign phase       = out_q.phase;
	assign pixel_valid = out_q.valid;
	assign pixel_value = out_q.pix;
	assign frame_end   = out_q.fend;
	assign frame_good  = out_q.fgood;
	assign good_frames = good_q;
	assign bad_frames  = bad_q;

endmodule

@@ sv/frame_sync_pattern_checker_top.sv @@
// Pushed bytes pass through a queue entry and then the output register.
// Throughput: one byte per cycle unless full; a four-entry queue between classifier
// and counters absorbs result-side stalls; full rises once all four entries are taken.
// Reset (arst_n low, asynchronous): initial sync, empty window, counters zero,
// configuration back to 250 x 200, marker AA55AA55, two sync markers.
module frame_sync_pattern_checker_top import fsp_pkg::*; #(
	parameter int INDEX_BITS  = FSP_INDEX_BITS,
	parameter int QUEUE_DEPTH = FSP_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  phase,
	output logic        pixel_valid,
	output logic [7:0]  pixel_value,
	output logic        frame_end,
	output logic        frame_good,
	output logic [15:0] good_frames,
	output logic [15:0] bad_frames
);

	fsp_rec_t rec;
	fsp_rec_t q_rdata;
	logic     take;
	logic     q_empty;
	logic     q_pop;

	assign take = push & ~full;

	fsp_front #(
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.take     (take),
		.rx_byte  (rx_byte),
		.rec      (rec)
	);

	fsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (take),
		.wdata  (rec),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.full   (full),
		.empty  (q_empty)
	);

	fsp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.phase       (phase),
		.pixel_valid (pixel_valid),
		.pixel_value (pixel_value),
		.frame_end   (frame_end),
		.frame_good  (frame_good),
		.good_frames (good_frames),
		.bad_frames  (bad_frames)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the frame sync and first-row pattern checker.
module tb;
	import fsp_pkg::*;

	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 60;
	localparam int IDLE_PCT     = 17;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_BYTES  = 70;
	localparam int MAX_REPORTS  = 40;

	// One result beat as seen on the output ports
	typedef struct packed {
		logic [1:0]  phase;
		logic        valid;
		logic [7:0]  pix;
		logic        fend;
		logic        fgood;
		logic [15:0] good_n;
		logic [15:0] bad_n;
	} frame_beat_t;

	// Tracks the checker's state, predicts each beat and holds the beats still due
	class frame_scoreboard;
		logic [11:0]     width_q;
		logic [11:0]     height_q;
		logic [31:0]     marker_q;
		logic [1:0]      sync_q;
		fsp_phase_t      phase_q;
		logic [23:0]     window_q;
		int unsigned     fill_q;
		int unsigned     found_q;
		longint unsigned index_q;
		bit              row_ok_q;
		int unsigned     good_q;
		int unsigned     bad_q;
		frame_beat_t     awaited_beats[$];
		int              errors;

		function new();
			width_q  = FRAME_WIDTH_RST;
			height_q = FRAME_HEIGHT_RST;
			marker_q = MARKER_WORD_RST;
			sync_q   = SYNC_MARKERS_RST;
			phase_q  = PH_SYNC;
			window_q = '0;
			fill_q   = 0;
			found_q  = 0;
			index_q  = 0;
			row_ok_q = 1'b1;
			good_q   = 0;
			bad_q    = 0;
			errors   = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				REG_FRAME_WIDTH:  width_q  = data[11:0];
				REG_FRAME_HEIGHT: height_q = data[11:0];
				REG_MARKER_WORD:  marker_q = data;
				REG_SYNC_MARKERS: sync_q   = data[1:0];
				default: ;
			endcase
		endfunction

		// Expected first-row byte: column mod 256 with the three swapped values
		function logic [7:0] pattern_at(longint unsigned col);
			logic [7:0] e;
			e = 8'(col & 64'hFF);
			if (e == PAT_AA)
				e = PAT_AB;
			else if (e == PAT_55)
				e = PAT_56;
			else if (e == PAT_FF)
				e = PAT_FE;
			return e;
		endfunction

		// Shift a byte into the window; empty it on a marker hit
		function bit marker_hit(logic [7:0] b);
			logic [31:0] word;
			word = {window_q, b};
			if (fill_q >= 3 && word == marker_q) begin
				window_q = '0;
				fill_q   = 0;
				return 1'b1;
			end
			window_q = word[23:0];
			if (fill_q < 3)
				fill_q++;
			return 1'b0;
		endfunction

		function void open_frame();
			phase_q  = PH_FRAME;
			index_q  = 0;
			row_ok_q = 1'b1;
		endfunction

		// Predict the beat for one accepted byte and queue it
		function void note_byte(logic [7:0] b);
			frame_beat_t     r;
			longint unsigned w;
			longint unsigned h;
			longint unsigned total;
			longint unsigned span;
			r = '0;
			r.phase = phase_q;
			span = 64'd1 << FSP_INDEX_BITS;
			case (phase_q)
				PH_SYNC: begin
					if (marker_hit(b)) begin
						if (found_q < 3)
							found_q++;
						if (found_q >= sync_q)
							open_frame();
					end
				end
				PH_FRAME: begin
					w = (width_q == 0) ? 1 : width_q;
					h = (height_q == 0) ? 1 : height_q;
					total = w * h;
					if (total > span)
						total = span;
					r.valid = 1'b1;
					r.pix   = b;
					if (index_q < w && b != pattern_at(index_q))
						row_ok_q = 1'b0;
					if (index_q >= total - 1) begin
						r.fend  = 1'b1;
						r.fgood = row_ok_q;
						if (row_ok_q) begin
							if (good_q < 16'hFFFF)
								good_q++;
						end else begin
							if (bad_q < 16'hFFFF)
								bad_q++;
						end
						phase_q  = PH_HUNT;
						window_q = '0;
						fill_q   = 0;
						index_q  = 0;
						row_ok_q = 1'b1;
					end else begin
						index_q = (index_q + 1) & (span - 1);
					end
				end
				default: begin
					if (marker_hit(b))
						open_frame();
				end
			endcase
			r.good_n = 16'(good_q);
			r.bad_n  = 16'(bad_q);
			awaited_beats.push_back(r);
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("t=%0t %s expected 0x%0h got 0x%0h", $time, name, want, got);
			end
		endfunction

		// Check one accepted beat against the oldest one due
		function void check_beat(frame_beat_t got);
			frame_beat_t want;
			if (awaited_beats.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("t=%0t beat with none due: expected nothing got 0x%0h",
						$time, got);
				return;
			end
			want = awaited_beats.pop_front();
			compare_field("phase", want.phase, got.phase);
			compare_field("pixel_valid", want.valid, got.valid);
			compare_field("pixel_value", want.pix, got.pix);
			compare_field("frame_end", want.fend, got.fend);
			compare_field("frame_good", want.fgood, got.fgood);
			compare_field("good_frames", want.good_n, got.good_n);
			compare_field("bad_frames", want.bad_n, got.bad_n);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [1:0]  phase;
	logic        pixel_valid;
	logic [7:0]  pixel_value;
	logic        frame_end;
	logic        frame_good;
	logic [15:0] good_frames;
	logic [15:0] bad_frames;

	frame_scoreboard fsb = new();
	bit          calm;
	bit          hold_req;
	int          sent_count;
	int          quiet_cycles;
	logic [11:0] cur_w;
	logic [11:0] cur_h;
	logic [31:0] cur_marker;

	frame_sync_pattern_checker_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.phase       (phase),
		.pixel_valid (pixel_valid),
		.pixel_value (pixel_value),
		.frame_end   (frame_end),
		.frame_good  (frame_good),
		.good_frames (good_frames),
		.bad_frames  (bad_frames)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one byte, idling at random first, and hold it until taken
	task automatic push_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		sent_count++;
		fsb.note_byte(b);
	endtask

	task automatic push_marker(input logic [31:0] m);
		for (int k = 3; k >= 0; k--)
			push_byte(m[8*k +: 8]);
	endtask

	task automatic push_noise(input int n);
		repeat (n) push_byte(8'($urandom));
	endtask

	// Leading bytes of the marker, then one that breaks it
	task automatic push_broken_marker(input logic [31:0] m);
		int cut;
		cut = $urandom_range(1, 3);
		for (int k = 0; k < cut; k++)
			push_byte(m[31 - 8*k -: 8]);
		push_byte(m[31 - 8*cut -: 8] ^ 8'(1 << $urandom_range(7)));
	endtask

	// A whole frame: first row follows the pattern unless spoilt at one column
	task automatic push_frame(input bit spoil);
		int unsigned w;
		int unsigned h;
		int unsigned bad_col;
		logic [7:0]  b;
		w = (cur_w == 0) ? 1 : cur_w;
		h = (cur_h == 0) ? 1 : cur_h;
		bad_col = $urandom_range(w - 1);
		for (int unsigned i = 0; i < w * h; i++) begin
			if (i < w) begin
				b = fsb.pattern_at(i);
				if (spoil && i == bad_col)
					b ^= 8'(1 << $urandom_range(7));
			end else begin
				b = 8'($urandom);
			end
			push_byte(b);
		end
	endtask

	// Stop offering and wait for every due beat, plus the pipeline depth
	task automatic settle();
		push <= 1'b0;
		while (fsb.awaited_beats.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_regs(input logic [11:0] w, input logic [11:0] h,
		input logic [31:0] m, input logic [1:0] s);
		logic [1:0]  idx [4];
		logic [31:0] val [4];
		idx = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_MARKER_WORD, REG_SYNC_MARKERS};
		val = '{32'(w), 32'(h), m, 32'(s)};
		for (int k = 0; k < 4; k++) begin
			wr_en    <= 1'b1;
			wr_index <= idx[k];
			wr_data  <= val[k];
			@(posedge clk);
			fsb.write_reg(idx[k], val[k]);
		end
		wr_en      <= 1'b0;
		cur_w      = w;
		cur_h      = h;
		cur_marker = m;
	endtask

	// Result side: pop at random, hold off for a long stretch on request
	initial begin
		frame_beat_t got;
		int          hold_left;
		pop       = 1'b0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = '{phase, pixel_valid, pixel_value, frame_end, frame_good,
					good_frames, bad_frames};
				fsb.check_beat(got);
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int          start;
		int          pick;
		logic [7:0]  rep;
		logic [11:0] w;
		logic [11:0] h;
		logic [31:0] m;
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = REG_FRAME_WIDTH;
		wr_data      = '0;
		push         = 1'b0;
		rx_byte      = '0;
		calm         = 1'b0;
		hold_req     = 1'b0;
		sent_count   = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Initial sync over three back-to-back markers, after a broken partial marker
		write_regs(12'd5, 12'd1, MARKER_WORD_RST, 2'd3);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(PAT_AA);
		push_byte(PAT_55);
		push_byte(PAT_AA);
		push_byte(8'h00);
		push_marker(MARKER_WORD_RST);
		push_marker(MARKER_WORD_RST);
		push_marker(MARKER_WORD_RST);
		push_frame(1'b0);
		settle();

		// Zero sizes act as one; an all-zero marker needs a full window after frame end
		write_regs(12'd0, 12'd0, 32'h0000_0000, 2'd0);
		push_marker(32'h0000_0000);
		push_byte(8'h00);
		push_marker(32'h0000_0000);
		push_byte(8'h5A);
		push_byte(8'h00);
		push_byte(8'h00);
		settle();

		// Long row: the pattern runs through every swapped value and wraps
		write_regs(12'd300, 12'd1, 32'hFFFF_FFFF, 2'd1);
		push_byte(8'h12);
		push_marker(32'hFFFF_FFFF);
		push_frame(1'b0);
		settle();

		// Tall frame, one column wide
		write_regs(12'd1, 12'd260, 32'($urandom), 2'd3);
		push_marker(cur_marker);
		push_frame(1'b1);
		settle();

		// Random settings and traffic, mostly well-formed marker and frame runs
		for (int k = 0; k < RAND_PHASES; k++) begin
			settle();
			w = ($urandom_range(99) < 70) ? 12'($urandom_range(1, 8)) :
				12'($urandom_range(9, 40));
			h = 12'($urandom_range(1, 5));
			pick = $urandom_range(2);
			rep = 8'($urandom);
			m = (pick == 0) ? {rep, rep, rep, rep} :
				(pick == 1) ? {PAT_AA, rep, PAT_55, rep} : 32'($urandom);
			write_regs(w, h, m, 2'($urandom));
			calm = (k == 3);
			if (k == 5)
				hold_req = 1'b1;
			start = sent_count;
			while (sent_count - start < PHASE_BYTES) begin
				pick = $urandom_range(99);
				push_noise($urandom_range(0, 5));
				if (pick < 15)
					push_broken_marker(cur_marker);
				if (pick < 92)
					push_marker(cur_marker);
				push_frame($urandom_range(99) < 35);
			end
			calm = 1'b0;
		end

		settle();
		repeat (8) @(posedge clk);
		if (fsb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
